// File: design/dscp_pkg.sv
// shared types, constants and coefficient tables for the degree sine/cosine pipeline
`timescale 1ns / 1ps
package dscp_pkg;

  localparam int ANGLE_WIDTH_DEF = 16;
  localparam int VALUE_W         = 15;
  localparam int REM_W           = 9;
  localparam int T_W             = 6;
  localparam int ACC_W           = 32;
  localparam int MAG_W           = 30;
  localparam int Q_W             = 14;
  localparam int RECIP_W         = 30;
  localparam int PROD_W          = MAG_W + RECIP_W;
  localparam int RED_STEPS       = 8;

  localparam int FULL_DEG    = 360;
  localparam int THREE_Q_DEG = 270;
  localparam int HALF_DEG    = 180;
  localparam int QUARTER_DEG = 90;
  localparam int EIGHTH_DEG  = 45;

  localparam logic [RECIP_W-1:0] LOW_RECIP  = 30'd879609303;
  localparam logic [RECIP_W-1:0] HIGH_RECIP = 30'd703687442;
  localparam int LOW_SHIFT  = 43;
  localparam int HIGH_SHIFT = 46;

  localparam logic signed [ACC_W-1:0] LOW_POLY [4] = '{
    -32'sd81, -32'sd277, 32'sd1747900, -32'sd1600
  };
  localparam logic signed [ACC_W-1:0] HIGH_POLY [4] = '{
    32'sd336, -32'sd161420, 32'sd75484, 32'sd999960000
  };

  typedef struct packed {
    logic sel_high;
    logic neg;
  } ctl_t;

  function automatic logic signed [ACC_W-1:0] poly_coef(input logic sel_high,
                                                        input logic [1:0] k);
    poly_coef = sel_high ? HIGH_POLY[k] : LOW_POLY[k];
  endfunction

endpackage

// File: design/degree_sine_cosine_poly_top.sv
// top level of the pipelined integer-degree sine and cosine unit
`timescale 1ns / 1ps
// Takes a whole-degree angle and an op (0 sine, 1 cosine) and returns the value
// in ten-thousandths, -10000..10000. Fully pipelined: one beat may enter every
// cycle while the output is not stalled, and results leave in order, one per
// beat. The stages are one input stage, the modulo 360 stages (up to eight
// compare-and-subtract steps each), a fold stage, three multiply-add stages of
// the cubic and three stages for the reciprocal divide and sign. Every stage
// has its own valid bit and takes a new beat whenever it is empty or its
// successor moves, so bubbles close up under a stall at the output.
module degree_sine_cosine_poly_top #(
  parameter int ANGLE_WIDTH = dscp_pkg::ANGLE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic signed [ANGLE_WIDTH-1:0]       in_angle_deg,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dscp_pkg::VALUE_W-1:0] out_value
);
  import dscp_pkg::*;

  localparam int NSTEP = ANGLE_WIDTH - 8;
  localparam int NRED  = (NSTEP + RED_STEPS - 1) / RED_STEPS;

  // input stage: cosine offset and magnitude
  logic                          s0_valid_r;
  logic [ANGLE_WIDTH-1:0]        s0_mag_r;
  logic                          s0_neg_r;
  logic signed [ANGLE_WIDTH:0]   ang_nxt;
  logic [ANGLE_WIDTH:0]          mag_full;
  logic                          s0_ready;

  always_comb begin
    ang_nxt  = {in_angle_deg[ANGLE_WIDTH-1], in_angle_deg}
             + (in_op ? (ANGLE_WIDTH+1)'(QUARTER_DEG) : '0);
    mag_full = ang_nxt[ANGLE_WIDTH] ? (~ang_nxt + (ANGLE_WIDTH+1)'(1)) : ang_nxt;
  end

  assign in_ready = !s0_valid_r || s0_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s0_mag_r <= mag_full[ANGLE_WIDTH-1:0];
      s0_neg_r <= ang_nxt[ANGLE_WIDTH];
    end
  end

  // modulo 360 reduction
  logic [ANGLE_WIDTH-1:0] red_mag   [NRED+1];
  logic                   red_neg   [NRED+1];
  logic                   red_valid [NRED+1];
  logic                   red_ready [NRED+1];

  assign red_mag[0]   = s0_mag_r;
  assign red_neg[0]   = s0_neg_r;
  assign red_valid[0] = s0_valid_r;
  assign s0_ready     = red_ready[0];

  for (genvar j = 0; j < NRED; j++) begin : g_red
    localparam int KH = NSTEP - 1 - RED_STEPS * j;
    localparam int NS = (KH + 1 > RED_STEPS) ? RED_STEPS : KH + 1;
    dscp_modstage #(
      .W    (ANGLE_WIDTH),
      .K_HI (KH),
      .N    (NS)
    ) u_modstage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (red_valid[j]),
      .in_ready  (red_ready[j]),
      .in_mag    (red_mag[j]),
      .in_neg    (red_neg[j]),
      .out_valid (red_valid[j+1]),
      .out_ready (red_ready[j+1]),
      .out_mag   (red_mag[j+1]),
      .out_neg   (red_neg[j+1])
    );
  end

  // fold
  logic           fold_valid;
  logic           fold_ready;
  logic [T_W-1:0] fold_t;
  ctl_t           fold_ctl;

  dscp_fold u_fold (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (red_valid[NRED]),
    .in_ready  (red_ready[NRED]),
    .in_rem    (red_mag[NRED][REM_W-1:0]),
    .in_neg    (red_neg[NRED]),
    .out_valid (fold_valid),
    .out_ready (fold_ready),
    .out_t     (fold_t),
    .out_ctl   (fold_ctl)
  );

  // cubic by Horner's rule
  logic                    h1_valid, h2_valid, h3_valid;
  logic                    h1_ready, h2_ready, h3_ready;
  logic signed [ACC_W-1:0] h1_acc, h2_acc, h3_acc;
  logic [T_W-1:0]          h1_t, h2_t, h3_t;
  ctl_t                    h1_ctl, h2_ctl, h3_ctl;

  dscp_horner u_horner1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fold_valid),
    .in_ready  (fold_ready),
    .in_acc    (poly_coef(fold_ctl.sel_high, 2'd0)),
    .in_coef   (poly_coef(fold_ctl.sel_high, 2'd1)),
    .in_t      (fold_t),
    .in_ctl    (fold_ctl),
    .out_valid (h1_valid),
    .out_ready (h1_ready),
    .out_acc   (h1_acc),
    .out_t     (h1_t),
    .out_ctl   (h1_ctl)
  );

  dscp_horner u_horner2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (h1_valid),
    .in_ready  (h1_ready),
    .in_acc    (h1_acc),
    .in_coef   (poly_coef(h1_ctl.sel_high, 2'd2)),
    .in_t      (h1_t),
    .in_ctl    (h1_ctl),
    .out_valid (h2_valid),
    .out_ready (h2_ready),
    .out_acc   (h2_acc),
    .out_t     (h2_t),
    .out_ctl   (h2_ctl)
  );

  dscp_horner u_horner3 (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (h2_valid),
    .in_ready  (h2_ready),
    .in_acc    (h2_acc),
    .in_coef   (poly_coef(h2_ctl.sel_high, 2'd3)),
    .in_t      (h2_t),
    .in_ctl    (h2_ctl),
    .out_valid (h3_valid),
    .out_ready (h3_ready),
    .out_acc   (h3_acc),
    .out_t     (h3_t),
    .out_ctl   (h3_ctl)
  );

  // divide and sign
  dscp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (h3_valid),
    .in_ready  (h3_ready),
    .in_acc    (h3_acc),
    .in_ctl    (h3_ctl),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value)
  );

  // checks
  a_value_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_value <= 15'sd10000 && out_value >= -15'sd10000))
    else $error("result outside -10000..10000");

  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    red_valid[NRED] |-> (red_mag[NRED] < ANGLE_WIDTH'(FULL_DEG)))
    else $error("angle not reduced below 360");

  a_fold_t: assert property (@(posedge clk) disable iff (!rst_n)
    h3_valid |-> (h3_t <= T_W'(EIGHTH_DEG)))
    else $error("folded cubic argument above 45");

endmodule

// File: design/dscp_modstage.sv
// one registered group of compare-and-subtract steps of the modulo 360 reduction
`timescale 1ns / 1ps
module dscp_modstage #(
  parameter int W    = 16,
  parameter int K_HI = 7,
  parameter int N    = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [W-1:0] in_mag,
  input  logic         in_neg,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [W-1:0] out_mag,
  output logic         out_neg
);
  import dscp_pkg::*;

  logic         valid_r;
  logic [W-1:0] mag_r;
  logic         neg_r;
  logic [W-1:0] mag_nxt;

  always_comb begin
    mag_nxt = in_mag;
    for (int i = 0; i < N; i++) begin
      if (mag_nxt >= (W'(FULL_DEG) << (K_HI - i))) begin
        mag_nxt = mag_nxt - (W'(FULL_DEG) << (K_HI - i));
      end
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_mag   = mag_r;
  assign out_neg   = neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mag_r <= mag_nxt;
      neg_r <= in_neg;
    end
  end

endmodule

// File: design/dscp_fold.sv
// quadrant fold of the reduced angle and choice of the low or high cubic
`timescale 1ns / 1ps
module dscp_fold (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dscp_pkg::REM_W-1:0]  in_rem,
  input  logic                        in_neg,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dscp_pkg::T_W-1:0]    out_t,
  output dscp_pkg::ctl_t              out_ctl
);
  import dscp_pkg::*;

  logic             valid_r;
  logic [T_W-1:0]   t_r;
  ctl_t             ctl_r;
  logic [REM_W-1:0] fa;
  logic             lneg;
  logic [REM_W-1:0] t_full;
  logic [T_W-1:0]   t_nxt;
  ctl_t             ctl_nxt;

  always_comb begin
    fa   = in_rem;
    lneg = 1'b0;
    if (in_rem <= REM_W'(QUARTER_DEG)) begin
      fa = in_rem;
    end else if (in_rem <= REM_W'(HALF_DEG)) begin
      fa = REM_W'(HALF_DEG) - in_rem;
    end else if (in_rem <= REM_W'(THREE_Q_DEG)) begin
      fa   = in_rem - REM_W'(HALF_DEG);
      lneg = 1'b1;
    end else begin
      fa   = REM_W'(FULL_DEG) - in_rem;
      lneg = 1'b1;
    end
    ctl_nxt.sel_high = fa > REM_W'(EIGHTH_DEG);
    ctl_nxt.neg      = in_neg ^ lneg;
    t_full           = ctl_nxt.sel_high ? (REM_W'(QUARTER_DEG) - fa) : fa;
    t_nxt            = t_full[T_W-1:0];
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_t     = t_r;
  assign out_ctl   = ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      t_r   <= t_nxt;
      ctl_r <= ctl_nxt;
    end
  end

endmodule

// File: design/dscp_horner.sv
// one registered multiply-add step of the cubic
`timescale 1ns / 1ps
module dscp_horner (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [dscp_pkg::ACC_W-1:0] in_acc,
  input  logic signed [dscp_pkg::ACC_W-1:0] in_coef,
  input  logic [dscp_pkg::T_W-1:0]          in_t,
  input  dscp_pkg::ctl_t                    in_ctl,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [dscp_pkg::ACC_W-1:0] out_acc,
  output logic [dscp_pkg::T_W-1:0]          out_t,
  output dscp_pkg::ctl_t                    out_ctl
);
  import dscp_pkg::*;

  localparam int P_W = ACC_W + T_W + 1;

  logic                    valid_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [T_W-1:0]          t_r;
  ctl_t                    ctl_r;
  logic signed [P_W-1:0]   prod;
  logic signed [P_W-1:0]   sum;
  logic signed [ACC_W-1:0] acc_nxt;

  always_comb begin
    prod    = P_W'(in_acc) * P_W'($signed({1'b0, in_t}));
    sum     = prod + P_W'(in_coef);
    acc_nxt = sum[ACC_W-1:0];
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_acc   = acc_r;
  assign out_t     = t_r;
  assign out_ctl   = ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      acc_r <= acc_nxt;
      t_r   <= in_t;
      ctl_r <= in_ctl;
    end
  end

endmodule

// File: design/dscp_div.sv
// truncating division by 10000 or 100000 through a reciprocal, then the sign
`timescale 1ns / 1ps
module dscp_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [dscp_pkg::ACC_W-1:0] in_acc,
  input  dscp_pkg::ctl_t                    in_ctl,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [dscp_pkg::VALUE_W-1:0] out_value
);
  import dscp_pkg::*;

  // stage 1: magnitude
  logic               v1_r;
  logic [MAG_W-1:0]   mag_r;
  logic               sel1_r;
  logic               neg1_r;
  logic [ACC_W-1:0]   abs_nxt;
  logic               rdy1;

  // stage 2: reciprocal multiply
  logic               v2_r;
  logic [Q_W-1:0]     q_r;
  logic               neg2_r;
  logic [PROD_W-1:0]  prod;
  logic [Q_W-1:0]     q_nxt;
  logic               rdy2;

  // stage 3: signed result
  logic                      v3_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [VALUE_W-1:0]        q_ext;
  logic [VALUE_W-1:0]        value_nxt;
  logic                      rdy3;

  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_comb begin
    abs_nxt = in_acc[ACC_W-1] ? (~in_acc + ACC_W'(1)) : in_acc;
    prod    = PROD_W'(mag_r) * PROD_W'(sel1_r ? HIGH_RECIP : LOW_RECIP);
    q_nxt   = sel1_r ? prod[HIGH_SHIFT +: Q_W] : prod[LOW_SHIFT +: Q_W];
    q_ext   = VALUE_W'(q_r);
    value_nxt = neg2_r ? (~q_ext + VALUE_W'(1)) : q_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      mag_r  <= abs_nxt[MAG_W-1:0];
      sel1_r <= in_ctl.sel_high;
      neg1_r <= in_ctl.neg ^ in_acc[ACC_W-1];
    end
    if (rdy2 && v1_r) begin
      q_r    <= q_nxt;
      neg2_r <= neg1_r;
    end
    if (rdy3 && v2_r) begin
      value_r <= value_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_value = value_r;

endmodule

// File: tb/tb_top.sv
// testbench for the pipelined integer-degree sine and cosine unit
`timescale 1ns / 1ps
module tb_top;

  localparam int AW = dscp_pkg::ANGLE_WIDTH_DEF;
  localparam int VW = dscp_pkg::VALUE_W;

  localparam logic OP_SINE   = 1'b0;
  localparam logic OP_COSINE = 1'b1;

  localparam int RANDOM_BEATS   = 1300;
  localparam int PRESSURE_BEATS = 250;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int CYCLE_LIMIT    = 200000;

  typedef enum logic [1:0] {
    RX_STEADY,
    RX_CHOPPY,
    RX_SPARSE
  } rx_mode_t;

  typedef struct {
    logic                 op;
    logic signed [AW-1:0] angle;
    logic signed [VW-1:0] value;
  } trig_expect_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_op = 1'b0;
  logic signed [AW-1:0] in_angle_deg = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [VW-1:0] out_value;

  trig_expect_t trig_due[$];
  int           mismatches = 0;
  int           cycles = 0;
  int           burst_left = 1;
  int           hold_req = 0;
  int           hold_ack = 0;
  int           hold_left = 0;
  int           seg_left = 0;
  rx_mode_t     rx_mode = RX_STEADY;

  degree_sine_cosine_poly_top #(
    .ANGLE_WIDTH(AW)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_op       (in_op),
    .in_angle_deg(in_angle_deg),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value   (out_value)
  );

  always #5 clk = ~clk;

  function automatic longint cubic_coef(input logic upper, input int k);
    case ({upper, k[1:0]})
      3'b000: return -81;
      3'b001: return -277;
      3'b010: return 1747900;
      3'b011: return -1600;
      3'b100: return 336;
      3'b101: return -161420;
      3'b110: return 75484;
      default: return 999960000;
    endcase
  endfunction

  function automatic longint eval_cubic(input logic upper, input longint t);
    longint acc;
    acc = 0;
    for (int k = 0; k < 4; k++) begin
      acc = acc * t + cubic_coef(upper, k);
    end
    return acc;
  endfunction

  // sine of a folded angle in 0..90
  function automatic longint quarter_sine(input longint a);
    if (a <= 45) begin
      return eval_cubic(1'b0, a) / 10000;
    end
    return eval_cubic(1'b1, 90 - a) / 100000;
  endfunction

  function automatic longint sine_of_deg(input longint ang);
    longint mag;
    longint r;
    longint q;
    mag = (ang < 0) ? -ang : ang;
    r = mag % 360;
    if (r <= 90) begin
      q = quarter_sine(r);
    end else if (r <= 180) begin
      q = quarter_sine(180 - r);
    end else if (r - 180 <= 90) begin
      q = -quarter_sine(r - 180);
    end else begin
      q = -quarter_sine(360 - r);
    end
    return (ang < 0) ? -q : q;
  endfunction

  function automatic logic signed [VW-1:0] trig_value(input logic op,
                                                      input logic signed [AW-1:0] angle);
    longint a;
    longint r;
    a = longint'(angle);
    if (op == OP_COSINE) begin
      a = a + 90;
    end
    r = sine_of_deg(a);
    return r[VW-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // random burst length, and a random gap after each burst
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      if ($urandom_range(0, 4) == 0) begin
        burst_left = $urandom_range(32, 96);
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 24);
        gap = $urandom_range(0, 8);
      end
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_beat(input logic op, input logic signed [AW-1:0] angle);
    trig_expect_t e;
    in_valid     <= 1'b1;
    in_op        <= op;
    in_angle_deg <= angle;
    do @(posedge clk); while (!in_ready);
    e.op    = op;
    e.angle = angle;
    e.value = trig_value(op, angle);
    trig_due.push_back(e);
    pace_sender();
  endtask

  function automatic logic signed [AW-1:0] pick_angle();
    int k;
    case ($urandom_range(0, 3))
      0: return AW'($urandom);
      1: return AW'($urandom_range(0, 1440) - 720);
      2: begin
        k = $urandom_range(0, 32) - 16;
        return AW'(k * 45 + $urandom_range(0, 2) - 1);
      end
      default: begin
        if ($urandom_range(0, 1) == 0) begin
          return AW'(32767 - $urandom_range(0, 120));
        end
        return AW'(-32768 + $urandom_range(0, 120));
      end
    endcase
  endfunction

  task automatic test_sine_edges();
    send_beat(OP_SINE, 0);
    send_beat(OP_SINE, 44);
    send_beat(OP_SINE, 45);
    send_beat(OP_SINE, 46);
    send_beat(OP_SINE, 90);
    send_beat(OP_SINE, 91);
    send_beat(OP_SINE, 135);
    send_beat(OP_SINE, 180);
    send_beat(OP_SINE, 225);
    send_beat(OP_SINE, 270);
    send_beat(OP_SINE, 359);
    send_beat(OP_SINE, 360);
    send_beat(OP_SINE, -1);
    send_beat(OP_SINE, -45);
    send_beat(OP_SINE, -90);
    send_beat(OP_SINE, 32767);
    send_beat(OP_SINE, -32768);
  endtask

  task automatic test_cosine_edges();
    send_beat(OP_COSINE, 0);
    send_beat(OP_COSINE, -45);
    send_beat(OP_COSINE, -90);
    send_beat(OP_COSINE, -91);
    send_beat(OP_COSINE, 270);
    send_beat(OP_COSINE, 32767);
    send_beat(OP_COSINE, -32768);
  endtask

  task automatic test_random_angles();
    for (int i = 0; i < RANDOM_BEATS; i++) begin
      send_beat(1'($urandom_range(0, 1)), pick_angle());
    end
  endtask

  // receiver holds off long enough that the pipeline fills and in_ready drops
  task automatic test_output_stall();
    hold_req <= hold_req + 1;
    for (int i = 0; i < PRESSURE_BEATS; i++) begin
      send_beat(1'($urandom_range(0, 1)), pick_angle());
    end
  endtask

  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_left <= $urandom_range(16, 160);
        rx_mode  <= rx_mode_t'($urandom_range(0, 2));
      end else begin
        seg_left <= seg_left - 1;
      end
      case (rx_mode)
        RX_STEADY: out_ready <= 1'b1;
        RX_CHOPPY: out_ready <= ($urandom_range(0, 1) == 0);
        default:   out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    trig_expect_t e;
    if (rst_n && out_valid && out_ready) begin
      if (trig_due.size() == 0) begin
        report_mismatch($sformatf("unexpected beat, value %0d", out_value));
      end else begin
        e = trig_due.pop_front();
        if (out_value !== e.value) begin
          report_mismatch($sformatf("op %0d angle %0d: value %0d, want %0d",
                                    e.op, e.angle, out_value, e.value));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats outstanding", cycles, trig_due.size());
      $display("** degree_sine_cosine_poly_top: FAILED **");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sine_edges();
    test_cosine_edges();
    test_random_angles();
    test_output_stall();
    in_valid <= 1'b0;
    while (trig_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** degree_sine_cosine_poly_top: PASSED **");
    end else begin
      $display("** degree_sine_cosine_poly_top: FAILED **");
    end
    $finish;
  end

endmodule
